// File: rtl/core/gasp_pkg.sv
// Shared constants for the grid A* path search block.
// Operation, cell and status codes plus the fixed neighbor order tables.
// No dependencies.
package gasp_pkg;

	localparam logic       OP_LOAD      = 1'b0;
	localparam logic       OP_SEARCH    = 1'b1;

	localparam logic [1:0] CODE_BLOCKED = 2'd1;

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_REJECT    = 2'd1;
	localparam logic [1:0] ST_NOPATH    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW  = 2'd3;

	localparam int         LEN_MAX      = 2047;

	// order: up, down, right, left, up-right, up-left, down-right, down-left
	function automatic logic signed [7:0] nb_dr(input logic [2:0] k);
		logic signed [7:0] d;
		unique case (k)
			3'd0, 3'd4, 3'd5: d = -8'sd1;
			3'd1, 3'd6, 3'd7: d = 8'sd1;
			default:          d = 8'sd0;
		endcase
		return d;
	endfunction

	function automatic logic signed [7:0] nb_dc(input logic [2:0] k);
		logic signed [7:0] d;
		unique case (k)
			3'd2, 3'd4, 3'd6: d = 8'sd1;
			3'd3, 3'd5, 3'd7: d = -8'sd1;
			default:          d = 8'sd0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/core/grid_astar_path_search.sv
// Grid A* path search: grid memory, per-search node memory and open list memory.
// Sequencer, bit-serial square root for the heuristic and the result register.
// Depends on gasp_pkg.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tuser: op; tdata: cell_row, cell_col, cell_code,
//          |     |        src_row, src_col, dst_row, dst_col
//  m_*     | out | tuser: status; tdata: path_length
//
// A load beat produces no result.
// A search beat holds s_tready low until its result is latched: endpoint checks, a
// clearing pass over the node flags, then per pop an open list scan, per neighbor
// the square root unit, and the parent walk over the path cells.
// The result register lets the next beat in while m_tvalid waits on m_tready.
// arst_n clears state, open count, status and m_tvalid; memories are not reset.
module grid_astar_path_search #(
	parameter int ROWS       = 32,
	parameter int COLS       = 32,
	parameter int OPEN_DEPTH = 1024,
	parameter int FRAC_BITS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [4:0] cell_row, [9:5] cell_col, [11:10] cell_code, [17:12] src_row,
	// [23:18] src_col, [29:24] dst_row, [35:30] dst_col, [39:36] zero
	input  logic [39:0] s_tdata,
	// [0] op
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [10:0] path_length, [15:11] zero
	output logic [15:0] m_tdata,
	// [1:0] status
	output logic [1:0]  m_tuser
);

	localparam int CELLS   = ROWS * COLS;
	localparam int CW      = $clog2(CELLS);
	localparam int OW      = $clog2(OPEN_DEPTH);
	localparam int RW      = 8 + FRAC_BITS;
	localparam int SW      = 2 * RW;
	localparam int SCW     = $clog2(RW + 1);
	localparam int GW      = CW + FRAC_BITS + 1;
	localparam int FW      = GW + 1;
	localparam int KW      = FW + 12;
	localparam int CSTW    = GW + FW + 3;
	localparam int LW      = CW + 2;
	localparam int DIAG_I  = (1414 * (1 << FRAC_BITS) + 500) / 1000;
	localparam logic [GW-1:0] STEP_S = GW'(1) << FRAC_BITS;
	localparam logic [GW-1:0] STEP_D = GW'(DIAG_I);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CHK_A  = 5'd1;
	localparam logic [4:0] S_CHK_B  = 5'd2;
	localparam logic [4:0] S_CHK_C  = 5'd3;
	localparam logic [4:0] S_CLEAR  = 5'd4;
	localparam logic [4:0] S_INIT   = 5'd5;
	localparam logic [4:0] S_POP    = 5'd6;
	localparam logic [4:0] S_SCAN   = 5'd7;
	localparam logic [4:0] S_FIX    = 5'd8;
	localparam logic [4:0] S_POP_G  = 5'd9;
	localparam logic [4:0] S_NB_CHK = 5'd10;
	localparam logic [4:0] S_NB_RD  = 5'd11;
	localparam logic [4:0] S_NB_EV  = 5'd12;
	localparam logic [4:0] S_SQRT   = 5'd13;
	localparam logic [4:0] S_NB_INS = 5'd14;
	localparam logic [4:0] S_WK_CHK = 5'd15;
	localparam logic [4:0] S_WK_RD  = 5'd16;
	localparam logic [4:0] S_WK_STP = 5'd17;
	localparam logic [4:0] S_DONE   = 5'd18;

	function automatic logic [CW-1:0] cell_idx(input logic [5:0] r, input logic [5:0] c);
		logic [12:0] t;
		t = 13'(r) * 13'(COLS) + 13'(c);
		return t[CW-1:0];
	endfunction

	// memories
	logic [1:0]      grid_mem [CELLS];
	logic [1:0]      flag_mem [CELLS];   // {closed, seen}
	logic [CSTW-1:0] cost_mem [CELLS];   // {g, f, parent}
	logic [KW-1:0]   open_mem [OPEN_DEPTH];

	logic            grid_we, grid_re, flag_we, flag_re, cost_we, cost_re, open_we, open_re;
	logic [CW-1:0]   grid_waddr, grid_raddr, flag_waddr, flag_raddr, cost_waddr, cost_raddr;
	logic [OW-1:0]   open_waddr, open_raddr;
	logic [1:0]      grid_wdata, flag_wdata;
	logic [CSTW-1:0] cost_wdata;
	logic [KW-1:0]   open_wdata;
	logic [1:0]      grid_rd_q, flag_rd_q;
	logic [CSTW-1:0] cost_rd_q;
	logic [KW-1:0]   open_rd_q;

	always_ff @(posedge clk) begin
		if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
		if (grid_re) grid_rd_q <= grid_mem[grid_raddr];
	end

	always_ff @(posedge clk) begin
		if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
		if (flag_re) flag_rd_q <= flag_mem[flag_raddr];
	end

	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
		if (cost_re) cost_rd_q <= cost_mem[cost_raddr];
	end

	always_ff @(posedge clk) begin
		if (open_we) open_mem[open_waddr] <= open_wdata;
		if (open_re) open_rd_q <= open_mem[open_raddr];
	end

	// control and working registers
	logic [4:0]    state_q;
	logic [5:0]    sr_q, sc_q, gr_q, gc_q;
	logic          blk_q;
	logic [CW-1:0] clr_q;
	logic [OW:0]   open_cnt_q, scan_addr_q;
	logic          rd_vld_s1;
	logic [OW-1:0] rd_idx_s1, best_idx_q;
	logic [KW-1:0] best_key_q, last_key_q;
	logic [5:0]    qr_q, qc_q;
	logic [GW-1:0] gq_q, gn_q;
	logic [2:0]    nb_q;
	logic [SW-1:0] sq_v_q;
	logic [RW+1:0] sq_rem_q;
	logic [RW-1:0] sq_root_q;
	logic [SCW-1:0] sq_cnt_q;
	logic [5:0]    wr_q, wc_q;
	logic [LW-1:0] len_q, guard_q;
	logic [1:0]    res_st_q;
	logic          m_tvalid_q;
	logic [1:0]    m_st_q;
	logic [10:0]   m_len_q;

	// input fields
	logic [4:0] in_cr, in_cc;
	logic [1:0] in_code;
	logic [5:0] in_sr, in_sc, in_dr, in_dc;
	logic       s_acc;

	assign in_cr   = s_tdata[4:0];
	assign in_cc   = s_tdata[9:5];
	assign in_code = s_tdata[11:10];
	assign in_sr   = s_tdata[17:12];
	assign in_sc   = s_tdata[23:18];
	assign in_dr   = s_tdata[29:24];
	assign in_dc   = s_tdata[35:30];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// neighbor of the expanded cell
	logic signed [7:0] nr_w, nc_w;
	logic              nb_in, nb_goal;
	logic [CW-1:0]     nb_idx;

	assign nr_w    = $signed({2'b00, qr_q}) + gasp_pkg::nb_dr(nb_q);
	assign nc_w    = $signed({2'b00, qc_q}) + gasp_pkg::nb_dc(nb_q);
	assign nb_in   = !nr_w[7] && (nr_w < $signed(8'(ROWS))) &&
	                 !nc_w[7] && (nc_w < $signed(8'(COLS)));
	assign nb_goal = (nr_w[5:0] == gr_q) && (nc_w[5:0] == gc_q);
	assign nb_idx  = cell_idx(nr_w[5:0], nc_w[5:0]);

	// node fields from the cost memory
	logic [GW-1:0] rd_g;
	logic [FW-1:0] rd_f;
	logic [2:0]    rd_par;
	assign rd_g   = cost_rd_q[CSTW-1 -: GW];
	assign rd_f   = cost_rd_q[FW+2:3];
	assign rd_par = cost_rd_q[2:0];

	// squared distance to the goal
	logic [5:0]  adr, adc;
	logic [11:0] sqr, sqc;
	logic [12:0] d2;
	assign adr = (nr_w[5:0] >= gr_q) ? (nr_w[5:0] - gr_q) : (gr_q - nr_w[5:0]);
	assign adc = (nc_w[5:0] >= gc_q) ? (nc_w[5:0] - gc_q) : (gc_q - nc_w[5:0]);
	assign sqr = 12'(adr) * 12'(adr);
	assign sqc = 12'(adc) * 12'(adc);
	assign d2  = 13'(sqr) + 13'(sqc);

	// one root bit per cycle
	logic [RW+1:0] sq_shift, sq_trial;
	assign sq_shift = {sq_rem_q[RW-1:0], sq_v_q[SW-1:SW-2]};
	assign sq_trial = {sq_root_q, 2'b01};

	logic [FW-1:0] fn_w;
	logic          ins_w, open_full;
	logic [KW-1:0] new_key;
	assign fn_w      = FW'(gn_q) + FW'(sq_root_q);
	assign ins_w     = !flag_rd_q[0] || (rd_f > fn_w);
	assign open_full = (open_cnt_q == (OW+1)'(OPEN_DEPTH));
	assign new_key   = {fn_w, nr_w[5:0], nc_w[5:0]};

	// parent walk
	logic signed [7:0] wnr_w, wnc_w;
	logic              wk_in, wk_end;
	assign wnr_w  = $signed({2'b00, wr_q}) - gasp_pkg::nb_dr(rd_par);
	assign wnc_w  = $signed({2'b00, wc_q}) - gasp_pkg::nb_dc(rd_par);
	assign wk_in  = !wnr_w[7] && (wnr_w < $signed(8'(ROWS))) &&
	                !wnc_w[7] && (wnc_w < $signed(8'(COLS)));
	assign wk_end = ((wr_q == sr_q) && (wc_q == sc_q)) || (32'(guard_q) >= CELLS);

	logic scan_more;
	assign scan_more = (scan_addr_q < open_cnt_q);

	// memory port control
	always_comb begin
		grid_we = 1'b0; grid_re = 1'b0; flag_we = 1'b0; flag_re = 1'b0;
		cost_we = 1'b0; cost_re = 1'b0; open_we = 1'b0; open_re = 1'b0;
		grid_waddr = cell_idx({1'b0, in_cr}, {1'b0, in_cc});
		grid_wdata = in_code;
		grid_raddr = cell_idx(sr_q, sc_q);
		flag_waddr = nb_idx;
		flag_wdata = 2'b01;
		flag_raddr = nb_idx;
		cost_waddr = nb_idx;
		cost_wdata = {gn_q, fn_w, nb_q};
		cost_raddr = nb_idx;
		open_waddr = open_cnt_q[OW-1:0];
		open_wdata = new_key;
		open_raddr = scan_addr_q[OW-1:0];
		unique case (state_q)
			S_IDLE: begin
				grid_we = s_acc && (s_tuser == gasp_pkg::OP_LOAD) &&
				          (32'(in_cr) < ROWS) && (32'(in_cc) < COLS);
			end
			S_CHK_A: grid_re = 1'b1;
			S_CHK_B: begin
				grid_re    = 1'b1;
				grid_raddr = cell_idx(gr_q, gc_q);
			end
			S_CLEAR: begin
				flag_we    = 1'b1;
				flag_waddr = clr_q;
				flag_wdata = 2'b00;
			end
			S_INIT: begin
				flag_we    = 1'b1;
				flag_waddr = cell_idx(sr_q, sc_q);
				cost_we    = 1'b1;
				cost_waddr = cell_idx(sr_q, sc_q);
				cost_wdata = '0;
				open_we    = 1'b1;
				open_waddr = '0;
				open_wdata = {{FW{1'b0}}, sr_q, sc_q};
			end
			S_SCAN: open_re = scan_more;
			S_FIX: begin
				open_we    = 1'b1;
				open_waddr = best_idx_q;
				open_wdata = last_key_q;
				flag_we    = 1'b1;
				flag_waddr = cell_idx(best_key_q[11:6], best_key_q[5:0]);
				flag_wdata = 2'b11;
				cost_re    = 1'b1;
				cost_raddr = cell_idx(best_key_q[11:6], best_key_q[5:0]);
			end
			S_NB_CHK: begin
				if (nb_in && nb_goal) begin
					cost_we    = 1'b1;
					cost_wdata = {{(GW+FW){1'b0}}, nb_q};
				end else if (nb_in) begin
					grid_re    = 1'b1;
					grid_raddr = nb_idx;
					flag_re    = 1'b1;
					cost_re    = 1'b1;
				end
			end
			S_NB_INS: begin
				open_we = ins_w && !open_full;
				flag_we = ins_w && !open_full;
				cost_we = ins_w && !open_full;
			end
			S_WK_CHK: begin
				cost_re    = !wk_end;
				cost_raddr = cell_idx(wr_q, wc_q);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			open_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
			res_st_q   <= gasp_pkg::ST_FOUND;
		end else begin
			if (m_tready && (state_q != S_DONE)) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_acc && (s_tuser == gasp_pkg::OP_SEARCH)) begin
						sr_q <= in_sr; sc_q <= in_sc; gr_q <= in_dr; gc_q <= in_dc;
						if ((32'(in_sr) >= ROWS) || (32'(in_sc) >= COLS) ||
						    (32'(in_dr) >= ROWS) || (32'(in_dc) >= COLS)) begin
							res_st_q <= gasp_pkg::ST_REJECT;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_CHK_A;
						end
					end
				end
				S_CHK_A: state_q <= S_CHK_B;
				S_CHK_B: begin
					blk_q   <= (grid_rd_q == gasp_pkg::CODE_BLOCKED);
					state_q <= S_CHK_C;
				end
				S_CHK_C: begin
					if (blk_q || (grid_rd_q == gasp_pkg::CODE_BLOCKED) ||
					    ((sr_q == gr_q) && (sc_q == gc_q))) begin
						res_st_q <= gasp_pkg::ST_REJECT;
						state_q  <= S_DONE;
					end else begin
						clr_q   <= '0;
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CELLS - 1)) state_q <= S_INIT;
				end
				S_INIT: begin
					open_cnt_q <= (OW+1)'(1);
					state_q    <= S_POP;
				end
				S_POP: begin
					if (open_cnt_q == '0) begin
						res_st_q <= gasp_pkg::ST_NOPATH;
						state_q  <= S_DONE;
					end else begin
						scan_addr_q <= '0;
						rd_vld_s1   <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one entry per cycle, the compare lands in the cycle after the read
					if (scan_more) scan_addr_q <= scan_addr_q + 1'b1;
					rd_vld_s1 <= scan_more;
					rd_idx_s1 <= scan_addr_q[OW-1:0];
					if (rd_vld_s1) begin
						if ((rd_idx_s1 == '0) || (open_rd_q < best_key_q)) begin
							best_key_q <= open_rd_q;
							best_idx_q <= rd_idx_s1;
						end
						if ((OW+1)'(rd_idx_s1) == open_cnt_q - 1'b1) last_key_q <= open_rd_q;
					end
					if (!scan_more && !rd_vld_s1) state_q <= S_FIX;
				end
				S_FIX: begin
					open_cnt_q <= open_cnt_q - 1'b1;
					qr_q       <= best_key_q[11:6];
					qc_q       <= best_key_q[5:0];
					state_q    <= S_POP_G;
				end
				S_POP_G: begin
					gq_q    <= rd_g;
					nb_q    <= '0;
					state_q <= S_NB_CHK;
				end
				S_NB_CHK: begin
					if (nb_in && nb_goal) begin
						wr_q    <= gr_q;
						wc_q    <= gc_q;
						len_q   <= LW'(1);
						guard_q <= '0;
						state_q <= S_WK_CHK;
					end else if (nb_in) begin
						state_q <= S_NB_RD;
					end else if (nb_q == 3'd7) begin
						state_q <= S_POP;
					end else begin
						nb_q <= nb_q + 1'b1;
					end
				end
				S_NB_RD: state_q <= S_NB_EV;
				S_NB_EV: begin
					if (flag_rd_q[1] || (grid_rd_q == gasp_pkg::CODE_BLOCKED)) begin
						if (nb_q == 3'd7) state_q <= S_POP;
						else begin
							nb_q    <= nb_q + 1'b1;
							state_q <= S_NB_CHK;
						end
					end else begin
						gn_q      <= gq_q + (nb_q[2] ? STEP_D : STEP_S);
						sq_v_q    <= SW'(d2) << (2 * FRAC_BITS);
						sq_rem_q  <= '0;
						sq_root_q <= '0;
						sq_cnt_q  <= '0;
						state_q   <= S_SQRT;
					end
				end
				S_SQRT: begin
					sq_v_q <= sq_v_q << 2;
					if (sq_shift >= sq_trial) begin
						sq_rem_q  <= sq_shift - sq_trial;
						sq_root_q <= {sq_root_q[RW-2:0], 1'b1};
					end else begin
						sq_rem_q  <= sq_shift;
						sq_root_q <= {sq_root_q[RW-2:0], 1'b0};
					end
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == SCW'(RW - 1)) state_q <= S_NB_INS;
				end
				S_NB_INS: begin
					if (ins_w && open_full) begin
						res_st_q <= gasp_pkg::ST_OVERFLOW;
						state_q  <= S_DONE;
					end else begin
						if (ins_w) open_cnt_q <= open_cnt_q + 1'b1;
						if (nb_q == 3'd7) state_q <= S_POP;
						else begin
							nb_q    <= nb_q + 1'b1;
							state_q <= S_NB_CHK;
						end
					end
				end
				S_WK_CHK: begin
					if (wk_end) begin
						res_st_q <= gasp_pkg::ST_FOUND;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_WK_RD;
					end
				end
				S_WK_RD: state_q <= S_WK_STP;
				S_WK_STP: begin
					if (!wk_in) begin
						res_st_q <= gasp_pkg::ST_FOUND;
						state_q  <= S_DONE;
					end else begin
						wr_q    <= wnr_w[5:0];
						wc_q    <= wnc_w[5:0];
						len_q   <= len_q + 1'b1;
						guard_q <= guard_q + 1'b1;
						state_q <= S_WK_CHK;
					end
				end
				S_DONE: begin
					// hold until the result register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_st_q     <= res_st_q;
						if (res_st_q != gasp_pkg::ST_FOUND) m_len_q <= '0;
						else if (32'(len_q) > gasp_pkg::LEN_MAX) m_len_q <= 11'(gasp_pkg::LEN_MAX);
						else m_len_q <= 11'(len_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_st_q;
	assign m_tdata  = {5'b00000, m_len_q};

endmodule

// File: rtl/core/gasp_port_chk.sv
// Port-level checks for the grid A* path search block, bound to its top level.
// Depends on gasp_pkg and grid_astar_path_search.
module gasp_port_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != gasp_pkg::ST_FOUND) |-> (m_tdata == 16'd0))
		else $error("nonzero length on a failed search");

	a_len_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == gasp_pkg::ST_FOUND) |->
		(m_tdata >= 16'd2) && (m_tdata <= 16'(gasp_pkg::LEN_MAX)))
		else $error("found path length out of range");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == gasp_pkg::OP_LOAD) |=> !$rose(m_tvalid))
		else $error("load beat produced a result");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == gasp_pkg::OP_SEARCH) |=> !s_tready)
		else $error("input ready right after a search beat");

endmodule

bind grid_astar_path_search gasp_port_chk u_gasp_port_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: bench/tb_grid_astar_path_search.sv
// Self-checking bench for grid_astar_path_search: loads grid cells, runs searches and checks
// status and path length against an in-bench A* predictor.
// Depends on gasp_pkg and the grid_astar_path_search RTL.
`timescale 1ns / 100ps

module tb_grid_astar_path_search;

	localparam int ROWS      = 32;
	localparam int COLS      = 32;
	localparam int NCELLS    = ROWS * COLS;
	localparam int OPEN_MAX  = 1024;
	localparam int FRAC      = 8;
	localparam int UNIT_COST = 1 << FRAC;
	localparam int DIAG_COST = (1414 * (1 << FRAC) + 500) / 1000;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] len;
	} path_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	grid_astar_path_search uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state
	logic [1:0]       grid_mem [NCELLS];
	bit               closed_q [NCELLS];
	bit               seen_q   [NCELLS];
	int unsigned      g_cost   [NCELLS];
	int unsigned      f_cost   [NCELLS];
	int               came_dir [NCELLS];
	longint unsigned  open_keys[$];
	const int         step_dr[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
	const int         step_dc[8] = '{0, 0, 1, -1, 1, -1, 1, -1};

	path_result_t pending_results[$];
	int           errors;
	int           burst_left;
	bit           hold_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000_000;
		$display("tb_grid_astar_path_search failed");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic int unsigned dist_to_goal(int r, int c, int gr, int gc);
		longint unsigned d2;
		d2 = longint'((r - gr) * (r - gr) + (c - gc) * (c - gc));
		return 32'(int_sqrt(d2 << (2 * FRAC)));
	endfunction

	function automatic longint unsigned take_min_key();
		int best;
		longint unsigned k;
		best = 0;
		for (int i = 1; i < open_keys.size(); i++)
			if (open_keys[i] < open_keys[best])
				best = i;
		k = open_keys[best];
		open_keys.delete(best);
		return k;
	endfunction

	function automatic int walk_parents(int sr, int sc, int gr, int gc);
		int r, c, k, n, guard;
		r = gr;
		c = gc;
		n = 1;
		guard = 0;
		while (!(r == sr && c == sc) && guard < NCELLS) begin
			k = came_dir[r * COLS + c];
			r -= step_dr[k];
			c -= step_dc[k];
			if (r < 0 || r >= ROWS || c < 0 || c >= COLS)
				break;
			n++;
			guard++;
		end
		return n;
	endfunction

	function automatic path_result_t run_astar(int sr, int sc, int gr, int gc);
		path_result_t res;
		longint unsigned key;
		int qr, qc, qi, nr, nc, ni, n;
		int unsigned gn, fn;
		res.status = gasp_pkg::ST_NOPATH;
		res.len = '0;
		if (sr >= ROWS || sc >= COLS || gr >= ROWS || gc >= COLS ||
			grid_mem[sr * COLS + sc] == gasp_pkg::CODE_BLOCKED ||
			grid_mem[gr * COLS + gc] == gasp_pkg::CODE_BLOCKED ||
			(sr == gr && sc == gc)) begin
			res.status = gasp_pkg::ST_REJECT;
			return res;
		end
		for (int i = 0; i < NCELLS; i++) begin
			closed_q[i] = 0;
			seen_q[i] = 0;
		end
		open_keys.delete();
		seen_q[sr * COLS + sc] = 1;
		g_cost[sr * COLS + sc] = 0;
		f_cost[sr * COLS + sc] = 0;
		open_keys.push_back((longint'(sr) << 6) | longint'(sc));
		while (open_keys.size() > 0) begin
			key = take_min_key();
			qr = int'((key >> 6) & 63);
			qc = int'(key & 63);
			qi = qr * COLS + qc;
			closed_q[qi] = 1;
			for (int k = 0; k < 8; k++) begin
				nr = qr + step_dr[k];
				nc = qc + step_dc[k];
				if (nr < 0 || nr >= ROWS || nc < 0 || nc >= COLS)
					continue;
				ni = nr * COLS + nc;
				if (nr == gr && nc == gc) begin
					came_dir[ni] = k;
					n = walk_parents(sr, sc, gr, gc);
					res.status = gasp_pkg::ST_FOUND;
					res.len = (n > gasp_pkg::LEN_MAX) ? 11'(gasp_pkg::LEN_MAX) : 11'(n);
					return res;
				end
				if (closed_q[ni] || grid_mem[ni] == gasp_pkg::CODE_BLOCKED)
					continue;
				gn = g_cost[qi] + ((k < 4) ? UNIT_COST : DIAG_COST);
				fn = gn + dist_to_goal(nr, nc, gr, gc);
				if (!seen_q[ni] || f_cost[ni] > fn) begin
					if (open_keys.size() >= OPEN_MAX) begin
						res.status = gasp_pkg::ST_OVERFLOW;
						return res;
					end
					open_keys.push_back((longint'(fn) << 12) | (longint'(nr) << 6) | longint'(nc));
					seen_q[ni] = 1;
					f_cost[ni] = fn;
					g_cost[ni] = gn;
					came_dir[ni] = k;
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// result checker
	initial begin
		path_result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected beat status %0d len %0d",
						m_tuser, m_tdata[10:0]));
				end else begin
					exp_r = pending_results.pop_front();
					if (m_tuser !== exp_r.status)
						report_mismatch($sformatf("status %0d, want %0d", m_tuser, exp_r.status));
					if (m_tdata[10:0] !== exp_r.len)
						report_mismatch($sformatf("length %0d, want %0d", m_tdata[10:0], exp_r.len));
				end
			end
		end
	end

	// receiver: stall patterns, plus one long hold-off on request
	initial begin
		int mode, mode_left;
		mode_left = 0;
		mode = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (12000) @(posedge clk);
				hold_req = 0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(10, 200);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	task automatic send_beat(logic op, int cr, int cc, int code, int sr, int sc, int gr, int gc);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, 6'(gc), 6'(gr), 6'(sc), 6'(sr), 2'(code), 5'(cc), 5'(cr)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == gasp_pkg::OP_LOAD)
			grid_mem[cr * COLS + cc] = 2'(code);
		else
			pending_results.push_back(run_astar(sr, sc, gr, gc));
	endtask

	task automatic load_cell(int r, int c, int code);
		send_beat(gasp_pkg::OP_LOAD, r, c, code, $urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom_range(0, 63));
	endtask

	task automatic find_path(int sr, int sc, int gr, int gc);
		send_beat(gasp_pkg::OP_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31),
			$urandom_range(0, 3), sr, sc, gr, gc);
	endtask

	// drop valid and wait for every result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic near_search();
		int sr, sc;
		sr = $urandom_range(0, ROWS - 1);
		sc = $urandom_range(0, COLS - 1);
		find_path(sr, sc, $urandom_range(sr > 5 ? sr - 5 : 0, sr < ROWS - 6 ? sr + 5 : ROWS - 1),
			$urandom_range(sc > 5 ? sc - 5 : 0, sc < COLS - 6 ? sc + 5 : COLS - 1));
	endtask

	// every cell is written before any search can read it; open codes vary
	task automatic test_grid_init();
		int open_codes[3] = '{0, 2, 3};
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				load_cell(r, c, open_codes[$urandom_range(0, 2)]);
		drain();
	endtask

	task automatic test_rejects();
		load_cell(5, 5, gasp_pkg::CODE_BLOCKED);
		find_path(63, 0, 1, 1);
		find_path(0, 63, 1, 1);
		find_path(1, 1, 32, 0);
		find_path(1, 1, 0, 32);
		find_path(5, 5, 7, 7);
		find_path(7, 7, 5, 5);
		find_path(9, 9, 9, 9);
		drain();
	endtask

	task automatic test_open_paths();
		find_path(0, 0, 31, 31);
		find_path(31, 0, 0, 31);
		find_path(12, 12, 12, 13);
		find_path(4, 7, 6, 9);
		find_path(20, 2, 20, 30);
		drain();
	endtask

	// a walled-in source leaves the open list empty after one expansion; a goal on the wall is rejected
	task automatic test_no_path();
		for (int k = 0; k < 8; k++)
			load_cell(10 + step_dr[k], 10 + step_dc[k], gasp_pkg::CODE_BLOCKED);
		find_path(10, 10, 20, 20);
		find_path(10, 10, 11, 11);
		drain();
		for (int k = 0; k < 8; k++)
			load_cell(10 + step_dr[k], 10 + step_dc[k], 0);
		load_cell(5, 5, 3);
		drain();
	endtask

	task automatic test_random();
		int pick;
		for (int i = 0; i < 20; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				load_cell($urandom_range(0, 31), $urandom_range(0, 31),
					($urandom_range(0, 3) == 0) ? gasp_pkg::CODE_BLOCKED : $urandom_range(0, 3));
			else if (pick < 62)
				find_path($urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63));
			else
				near_search();
		end
		drain();
	endtask

	// receiver holds off while searches keep coming, so the input stalls
	task automatic test_backpressure();
		hold_req = 1;
		for (int i = 0; i < 6; i++)
			near_search();
		drain();
	endtask

	task automatic test_long_search();
		find_path(0, 0, 31, 31);
		find_path(0, 31, 31, 0);
		find_path(16, 0, 16, 31);
		drain();
	endtask

	initial begin
		errors = 0;
		burst_left = 0;
		hold_req = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_grid_init();
		test_rejects();
		test_open_paths();
		test_no_path();
		test_random();
		test_backpressure();
		test_long_search();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_grid_astar_path_search passed");
		else
			$display("tb_grid_astar_path_search failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/gasp_pkg.sv
rtl/core/grid_astar_path_search.sv
rtl/core/gasp_port_chk.sv
bench/tb_grid_astar_path_search.sv
